// ===== hw/rtl/bounded_positional_list_top_macros.svh =====
// ----------------------------------------------------------------------------
// bounded positional list assertion macros
// shared concurrent assertion forms for the list checker
// ----------------------------------------------------------------------------
`ifndef BOUNDED_POSITIONAL_LIST_TOP_MACROS_SVH
`define BOUNDED_POSITIONAL_LIST_TOP_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BPL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define BPL_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `BPL_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== hw/rtl/bpl_pkg.sv =====
// ----------------------------------------------------------------------------
// bounded positional list package
// request and response types, operation and status codes, cell control
// ----------------------------------------------------------------------------
package bpl_pkg;

  localparam int CapacityDef   = 4;
  localparam int ValueWidthDef = 32;
  // slot index width wide enough for the largest supported capacity
  localparam int IdxW          = 6;

  typedef enum logic [3:0] {
    OP_INS_FIRST = 4'd0,
    OP_INS_LAST  = 4'd1,
    OP_UPD_FIRST = 4'd2,
    OP_UPD_LAST  = 4'd3,
    OP_DEL_FIRST = 4'd4,
    OP_DEL_LAST  = 4'd5,
    OP_INS_AFTER = 4'd6,
    OP_UPD_AFTER = 4'd7,
    OP_DEL_AFTER = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_WRITE  = 2'd2,
    ACT_REMOVE = 2'd3
  } act_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [2:0]  position;
    logic [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] old_value;
    logic [2:0]  length;
  } out_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    act_e            action;
    logic [IdxW-1:0] at;
  } ctl_t;

endpackage

// ===== hw/rtl/bounded_positional_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded positional list
// ordered list of up to CAPACITY words with insert/update/delete at either end
// or just after an index
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid_i / in_stall_o carry one request (operation,
//   position, item_value). out channel: out_valid_o / out_stall_i carry one
//   response (status, old_value, length) for every request.
//   latency: a request accepted at one edge has its response on the output
//   register from the next cycle on.
//   throughput: one request per cycle unless stalled. the list lives in a
//   chain of cells, one slot each; every cell picks its next value from
//   itself, its left or right neighbor or the request word in the same
//   cycle, so the whole shift happens at once and nothing iterates.
//   stall: while a response waits with out_stall_i high, in_stall_o is high
//   and the list state holds; the response stays unchanged until taken.
//   reset: the entry count goes to zero and no response is pending; the slot
//   words are not cleared, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_positional_list_top #(
  parameter int CAPACITY    = bpl_pkg::CapacityDef,
  parameter int VALUE_WIDTH = bpl_pkg::ValueWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  bpl_pkg::in_t in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output bpl_pkg::out_t out_rsp_o
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int EW  = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  localparam int LW  = (CW > 3) ? CW : 3;

  // entry count and output register
  logic [CW-1:0]    count_q, count_d;
  logic             out_valid_q;
  bpl_pkg::out_t    rsp_q;

  // decode results
  bpl_pkg::ctl_t    dec_ctl, cell_ctl;
  bpl_pkg::status_e dec_status;
  logic             accept;

  // chain wiring
  logic [VALUE_WIDTH-1:0] value_in;
  logic [VALUE_WIDTH-1:0] slot_w [CAPACITY];
  logic [VALUE_WIDTH-1:0] pick_w [CAPACITY+1];

  logic [EW-1:0]    old_wide;
  logic [LW-1:0]    len_wide;
  logic [31:0]      old_value;

  // a new request goes in unless a response is held by the receiver
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // the request word is cut or zero-extended to the slot width
  assign value_in = VALUE_WIDTH'(in_req_i.item_value);

  bpl_decode #(
    .CAPACITY (CAPACITY)
  ) u_decode (
    .req_i    (in_req_i),
    .count_i  (count_q),
    .ctl_o    (dec_ctl),
    .status_o (dec_status),
    .count_o  (count_d)
  );

  // cells only move on an accepted request
  always_comb begin
    cell_ctl = dec_ctl;
    if (!accept) begin
      cell_ctl.action = bpl_pkg::ACT_HOLD;
    end
  end

  assign pick_w[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v, right_v;

    // end cells see the request word / zero where no neighbor exists;
    // the decode never asks the first cell to shift from there; a remove shifts zero into the last
    if (i == 0) begin : g_first
      assign left_v = value_in;
    end else begin : g_left
      assign left_v = slot_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_right
      assign right_v = slot_w[i+1];
    end

    bpl_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .INDEX       (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .value_i (value_in),
      .left_i  (left_v),
      .right_i (right_v),
      .pick_i  (pick_w[i]),
      .slot_o  (slot_w[i]),
      .pick_o  (pick_w[i+1])
    );
  end

  // old value only reported for a successful update or delete
  assign old_wide  = EW'(pick_w[CAPACITY]);
  assign old_value = ((dec_ctl.action == bpl_pkg::ACT_WRITE) ||
                      (dec_ctl.action == bpl_pkg::ACT_REMOVE)) ? old_wide[31:0] : '0;
  assign len_wide  = LW'(count_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (accept) begin
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q.status    <= dec_status;
      rsp_q.old_value <= old_value;
      rsp_q.length    <= len_wide[2:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== hw/rtl/bpl_cell.sv =====
// ----------------------------------------------------------------------------
// bounded positional list cell
// one slot of the list; shifts toward or from its neighbors on insert/remove
// ----------------------------------------------------------------------------
module bpl_cell #(
  parameter int VALUE_WIDTH = bpl_pkg::ValueWidthDef,
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  bpl_pkg::ctl_t          ctl_i,
  input  logic [VALUE_WIDTH-1:0] value_i,
  input  logic [VALUE_WIDTH-1:0] left_i,
  input  logic [VALUE_WIDTH-1:0] right_i,
  input  logic [VALUE_WIDTH-1:0] pick_i,
  output logic [VALUE_WIDTH-1:0] slot_o,
  output logic [VALUE_WIDTH-1:0] pick_o
);

  localparam logic [bpl_pkg::IdxW-1:0] MyIdx = bpl_pkg::IdxW'(INDEX);

  logic [VALUE_WIDTH-1:0] slot_q, slot_d;
  logic                   hit, above;

  assign hit   = (ctl_i.at == MyIdx);
  assign above = (ctl_i.at < MyIdx);

  always_comb begin
    slot_d = slot_q;
    case (ctl_i.action)
      bpl_pkg::ACT_INSERT: begin
        if (hit) begin
          slot_d = value_i;
        end else if (above) begin
          slot_d = left_i;
        end
      end
      bpl_pkg::ACT_WRITE: begin
        if (hit) begin
          slot_d = value_i;
        end
      end
      bpl_pkg::ACT_REMOVE: begin
        if (hit || above) begin
          slot_d = right_i;
        end
      end
      default: slot_d = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  // old value travels down the chain, picked up by the addressed cell
  assign pick_o = pick_i | (hit ? slot_q : '0);
  assign slot_o = slot_q;

endmodule

// ===== hw/rtl/bpl_decode.sv =====
// ----------------------------------------------------------------------------
// bounded positional list decode
// checks a request against the entry count and forms the cell control
// ----------------------------------------------------------------------------
module bpl_decode #(
  parameter int CAPACITY = bpl_pkg::CapacityDef,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  bpl_pkg::in_t      req_i,
  input  logic [CW-1:0]     count_i,
  output bpl_pkg::ctl_t     ctl_o,
  output bpl_pkg::status_e  status_o,
  output logic [CW-1:0]     count_o
);

  localparam int CmpW = (CW > 4) ? CW : 4;

  logic            full, empty;
  logic [CmpW-1:0] pos_x, pos_inc, cnt_x;
  logic [CW-1:0]   last_idx;

  assign full     = (count_i == CW'(CAPACITY));
  assign empty    = (count_i == '0);
  assign pos_x    = CmpW'(req_i.position);
  assign pos_inc  = pos_x + CmpW'(1);
  assign cnt_x    = CmpW'(count_i);
  assign last_idx = count_i - CW'(1);

  always_comb begin
    ctl_o.action = bpl_pkg::ACT_HOLD;
    ctl_o.at     = '0;
    status_o     = bpl_pkg::ST_OK;
    count_o      = count_i;
    case (req_i.operation)
      bpl_pkg::OP_INS_FIRST, bpl_pkg::OP_INS_LAST: begin
        if (full) begin
          status_o = bpl_pkg::ST_FULL;
        end else begin
          ctl_o.action = bpl_pkg::ACT_INSERT;
          ctl_o.at     = (req_i.operation == bpl_pkg::OP_INS_FIRST) ?
                         '0 : bpl_pkg::IdxW'(count_i);
          count_o      = count_i + CW'(1);
        end
      end
      bpl_pkg::OP_UPD_FIRST, bpl_pkg::OP_UPD_LAST: begin
        if (empty) begin
          status_o = bpl_pkg::ST_EMPTY;
        end else begin
          ctl_o.action = bpl_pkg::ACT_WRITE;
          ctl_o.at     = (req_i.operation == bpl_pkg::OP_UPD_FIRST) ?
                         '0 : bpl_pkg::IdxW'(last_idx);
        end
      end
      bpl_pkg::OP_DEL_FIRST, bpl_pkg::OP_DEL_LAST: begin
        if (empty) begin
          status_o = bpl_pkg::ST_EMPTY;
        end else begin
          ctl_o.action = bpl_pkg::ACT_REMOVE;
          ctl_o.at     = (req_i.operation == bpl_pkg::OP_DEL_FIRST) ?
                         '0 : bpl_pkg::IdxW'(last_idx);
          count_o      = last_idx;
        end
      end
      bpl_pkg::OP_INS_AFTER: begin
        if (full) begin
          status_o = bpl_pkg::ST_FULL;
        end else if (pos_x >= cnt_x) begin
          status_o = bpl_pkg::ST_BAD_INDEX;
        end else begin
          ctl_o.action = bpl_pkg::ACT_INSERT;
          ctl_o.at     = bpl_pkg::IdxW'(pos_inc);
          count_o      = count_i + CW'(1);
        end
      end
      bpl_pkg::OP_UPD_AFTER, bpl_pkg::OP_DEL_AFTER: begin
        if (pos_inc >= cnt_x) begin
          status_o = bpl_pkg::ST_BAD_INDEX;
        end else if (req_i.operation == bpl_pkg::OP_UPD_AFTER) begin
          ctl_o.action = bpl_pkg::ACT_WRITE;
          ctl_o.at     = bpl_pkg::IdxW'(pos_inc);
        end else begin
          ctl_o.action = bpl_pkg::ACT_REMOVE;
          ctl_o.at     = bpl_pkg::IdxW'(pos_inc);
          count_o      = last_idx;
        end
      end
      default: begin
        // undefined codes leave the list as it is and report ok
        ctl_o.action = bpl_pkg::ACT_HOLD;
      end
    endcase
  end

endmodule

// ===== hw/rtl/bpl_checker.sv =====
// ----------------------------------------------------------------------------
// bounded positional list checker
// port-level properties of the list, bound to the top level
// ----------------------------------------------------------------------------
`include "bounded_positional_list_top_macros.svh"

module bpl_checker #(
  parameter int CAPACITY = bpl_pkg::CapacityDef
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input bpl_pkg::out_t out_rsp_o
);

  logic in_take;
  logic rsp_fail;

  assign in_take  = in_valid_i && !in_stall_o;
  assign rsp_fail = out_rsp_o.status != bpl_pkg::ST_OK;

  // held response does not change
  `BPL_ASSERT(a_rsp_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o), "held response changed")

  // every accepted request has its response valid in the next cycle
  `BPL_ASSERT(a_rsp_latency, clk_i, rst_ni, in_take |=> out_valid_o, "response missing after request")

  // failed requests report no old value
  `BPL_ASSERT(a_fail_no_old, clk_i, rst_ni, out_valid_o && rsp_fail |-> out_rsp_o.old_value == '0, "old value on failed request")

  // full and empty reports agree with the length, checked only for CAPACITY below 8
  `BPL_ASSERT_NEVER(a_full_empty_len, clk_i, rst_ni, out_valid_o && (CAPACITY < 8) && (((out_rsp_o.status == bpl_pkg::ST_FULL) && (out_rsp_o.length != CAPACITY)) || ((out_rsp_o.status == bpl_pkg::ST_EMPTY) && (out_rsp_o.length != 0)) || (out_rsp_o.length > CAPACITY)), "length disagrees with status")

endmodule

bind bounded_positional_list_top bpl_checker #(
  .CAPACITY (CAPACITY)
) u_bpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

// ===== bench/bounded_positional_list_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded positional list testbench
// drives directed and random list requests under random bursts and output stalls, keeps a shadow
// copy of the list contents and checks every response field in order
// ----------------------------------------------------------------------------
module bounded_positional_list_top_test;

  localparam int CAP = bpl_pkg::CapacityDef;
  // codes past the last defined operation, the block must leave them alone
  localparam logic [3:0] OP_UNDEF_LO = 4'd9;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int RandomItems = 1700;

  // shadow of the list: slot words, entry count and the responses still owed
  class list_shadow;
    logic [31:0] words [CAP];
    int unsigned held;
    bpl_pkg::out_t awaited_q [$];
    int unsigned mismatches;

    function new();
      held = 0;
      mismatches = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    // open a hole at slot at, shifting the tail right
    function void open_slot(int unsigned at, logic [31:0] v);
      for (int unsigned i = held; i > at; i--) words[i] = words[i-1];
      words[at] = v;
      held++;
    endfunction

    // take out slot at, shifting the tail left
    function logic [31:0] close_slot(int unsigned at);
      logic [31:0] v;
      v = words[at];
      for (int unsigned i = at; i + 1 < held; i++) words[i] = words[i+1];
      held--;
      return v;
    endfunction

    // apply one accepted request and queue the response it must produce
    function void apply_request(bpl_pkg::in_t req);
      bpl_pkg::out_t want;
      int unsigned pos;
      int unsigned at;
      want = '0;
      want.status = bpl_pkg::ST_OK;
      pos = req.position;
      case (req.operation)
        bpl_pkg::OP_INS_FIRST, bpl_pkg::OP_INS_LAST: begin
          if (held >= CAP) want.status = bpl_pkg::ST_FULL;
          else open_slot((req.operation == bpl_pkg::OP_INS_FIRST) ? 0 : held,
                         req.item_value);
        end
        bpl_pkg::OP_UPD_FIRST, bpl_pkg::OP_UPD_LAST: begin
          if (held == 0) want.status = bpl_pkg::ST_EMPTY;
          else begin
            at = (req.operation == bpl_pkg::OP_UPD_FIRST) ? 0 : held - 1;
            want.old_value = words[at];
            words[at] = req.item_value;
          end
        end
        bpl_pkg::OP_DEL_FIRST, bpl_pkg::OP_DEL_LAST: begin
          if (held == 0) want.status = bpl_pkg::ST_EMPTY;
          else want.old_value = close_slot(
                 (req.operation == bpl_pkg::OP_DEL_FIRST) ? 0 : held - 1);
        end
        bpl_pkg::OP_INS_AFTER: begin
          // full wins over a bad index
          if (held >= CAP) want.status = bpl_pkg::ST_FULL;
          else if (pos >= held) want.status = bpl_pkg::ST_BAD_INDEX;
          else open_slot(pos + 1, req.item_value);
        end
        bpl_pkg::OP_UPD_AFTER, bpl_pkg::OP_DEL_AFTER: begin
          if (pos + 1 >= held) want.status = bpl_pkg::ST_BAD_INDEX;
          else if (req.operation == bpl_pkg::OP_UPD_AFTER) begin
            want.old_value = words[pos + 1];
            words[pos + 1] = req.item_value;
          end else begin
            want.old_value = close_slot(pos + 1);
          end
        end
        default: ;
      endcase
      want.length = held[2:0];
      awaited_q.push_back(want);
    endfunction

    // compare one accepted response against the oldest owed one
    function void match_response(bpl_pkg::out_t got);
      bpl_pkg::out_t want;
      if (awaited_q.size() == 0) begin
        $error("response with nothing owed: status %0d old_value 0x%08h length %0d",
               got.status, got.old_value, got.length);
        mismatches++;
        return;
      end
      want = awaited_q.pop_front();
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.old_value !== want.old_value) begin
        $error("old_value mismatch: expected 0x%08h, actual 0x%08h",
               want.old_value, got.old_value);
        mismatches++;
      end
      if (got.length !== want.length) begin
        $error("length mismatch: expected %0d, actual %0d", want.length, got.length);
        mismatches++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  bpl_pkg::in_t  in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  bpl_pkg::out_t out_rsp_o;

  list_shadow shadow = new();

  // run statistics for the closing summary
  int unsigned req_count;
  int unsigned rsp_count;
  int unsigned undef_count;
  int unsigned status_seen [4];
  int unsigned longest_hold;

  bounded_positional_list_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("bounded_positional_list_top_test: FAIL");
    $finish;
  end

  // ----------------------------------------------------------------------------
  // monitor: both handshakes sampled on the edge, before any new drive lands
  // ----------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // a response taken here always belongs to a request taken on an earlier edge
      if (out_valid_o && !out_stall_i) begin
        shadow.match_response(out_rsp_o);
        rsp_count++;
        status_seen[out_rsp_o.status]++;
      end
      if (in_valid_i && !in_stall_o) begin
        shadow.apply_request(in_req_i);
        req_count++;
      end
    end
  end

  // ----------------------------------------------------------------------------
  // receiver: stall pattern in segments, free flow, random, alternating, or a
  // long hold-off that lets the block back up and stall its input
  // ----------------------------------------------------------------------------
  initial begin
    int unsigned seg;
    int unsigned seg_len;
    int unsigned mode;
    bit phase;
    seg = 0;
    phase = 1'b0;
    longest_hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      seg++;
      seg_len = $urandom_range(10, 120);
      mode = $urandom_range(0, 3);
      // the first hold-off lands early, while the sender is still busy
      if (seg == 2 || (seg > 2 && $urandom_range(0, 7) == 0)) begin
        seg_len = $urandom_range(60, 150);
        if (seg_len > longest_hold) longest_hold = seg_len;
        repeat (seg_len) begin
          @(posedge clk_i);
          out_stall_i <= 1'b1;
        end
      end else begin
        repeat (seg_len) begin
          @(posedge clk_i);
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(0, 2) == 0);
            2: begin
              phase = ~phase;
              out_stall_i <= phase;
            end
            default: out_stall_i <= ($urandom_range(0, 5) != 0);
          endcase
        end
      end
    end
  end

  // hold one request on the channel until it is taken
  task automatic offer(input logic [3:0] op, input logic [2:0] pos, input logic [31:0] val);
    bpl_pkg::in_t req;
    req.operation  = op;
    req.position   = pos;
    req.item_value = val;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender gap
  task automatic pause(input int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // ----------------------------------------------------------------------------
  // sender: reset, directed corner requests, then random bursts
  // ----------------------------------------------------------------------------
  initial begin
    int unsigned real_items;
    int unsigned burst_left;
    int unsigned r;
    int unsigned k;
    int unsigned ins_share;
    int unsigned del_share;
    bit growing;
    logic [3:0] op;
    logic [2:0] pos;
    logic [31:0] val;

    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: updates and deletes report empty, after-index ops bad index
    offer(bpl_pkg::OP_UPD_FIRST, 3'd0, 32'h1111_1111);
    offer(bpl_pkg::OP_UPD_LAST,  3'd0, 32'h2222_2222);
    offer(bpl_pkg::OP_DEL_FIRST, 3'd0, 32'h0);
    offer(bpl_pkg::OP_DEL_LAST,  3'd0, 32'h0);
    offer(bpl_pkg::OP_INS_AFTER, 3'd0, 32'h3333_3333);
    offer(bpl_pkg::OP_UPD_AFTER, 3'd0, 32'h4444_4444);
    offer(bpl_pkg::OP_DEL_AFTER, 3'd7, 32'h0);
    // undefined codes leave everything as is
    offer(OP_UNDEF_LO,  3'd5, 32'hFFFF_FFFF);
    offer(OP_UNDEF_HI,  3'd2, 32'h5555_5555);
    // fill to capacity with the value extremes
    offer(bpl_pkg::OP_INS_FIRST, 3'd0, 32'hFFFF_FFFF);
    offer(bpl_pkg::OP_INS_LAST,  3'd0, 32'h0000_0000);
    offer(bpl_pkg::OP_INS_AFTER, 3'd0, 32'hA5A5_A5A5);
    offer(bpl_pkg::OP_INS_AFTER, 3'd2, 32'h5A5A_5A5A);
    // full list: every insert reports full, full checked before the index
    offer(bpl_pkg::OP_INS_FIRST, 3'd0, 32'h6666_6666);
    offer(bpl_pkg::OP_INS_LAST,  3'd0, 32'h7777_7777);
    offer(bpl_pkg::OP_INS_AFTER, 3'd7, 32'h8888_8888);
    // updates at both ends and after an index, last legal and first bad index
    offer(bpl_pkg::OP_UPD_FIRST, 3'd0, 32'h0000_0001);
    offer(bpl_pkg::OP_UPD_LAST,  3'd0, 32'h8000_0000);
    offer(bpl_pkg::OP_UPD_AFTER, 3'd2, 32'hDEAD_BEEF);
    offer(bpl_pkg::OP_UPD_AFTER, 3'd3, 32'h9999_9999);
    offer(bpl_pkg::OP_DEL_AFTER, 3'd7, 32'h0);
    // drain back to empty
    offer(bpl_pkg::OP_DEL_AFTER, 3'd1, 32'h0);
    offer(bpl_pkg::OP_DEL_FIRST, 3'd0, 32'h0);
    offer(bpl_pkg::OP_DEL_LAST,  3'd0, 32'h0);
    offer(bpl_pkg::OP_DEL_LAST,  3'd0, 32'h0);
    undef_count = 2;

    // random part: the list swings between filling and draining phases so
    // every count from empty to full is visited, with a little noise on top
    real_items = 0;
    burst_left = 0;
    growing = 1'b1;
    while (real_items < RandomItems) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
        burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      if ($urandom_range(0, 11) == 0) growing = ~growing;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
      end else begin
        k = $urandom_range(0, 99);
        ins_share = growing ? 55 : 20;
        del_share = growing ? 20 : 55;
        if (k < ins_share) begin
          case ($urandom_range(0, 2))
            0:       op = bpl_pkg::OP_INS_FIRST;
            1:       op = bpl_pkg::OP_INS_LAST;
            default: op = bpl_pkg::OP_INS_AFTER;
          endcase
        end else if (k < ins_share + del_share) begin
          case ($urandom_range(0, 2))
            0:       op = bpl_pkg::OP_DEL_FIRST;
            1:       op = bpl_pkg::OP_DEL_LAST;
            default: op = bpl_pkg::OP_DEL_AFTER;
          endcase
        end else begin
          case ($urandom_range(0, 2))
            0:       op = bpl_pkg::OP_UPD_FIRST;
            1:       op = bpl_pkg::OP_UPD_LAST;
            default: op = bpl_pkg::OP_UPD_AFTER;
          endcase
        end
      end
      // positions mostly below the capacity, sometimes anywhere in the field
      pos = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, CAP - 1)) :
                                           3'($urandom_range(0, 7));
      case ($urandom_range(0, 19))
        0:       val = 32'h0000_0000;
        1:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      offer(op, pos, val);
      if (op > bpl_pkg::OP_DEL_AFTER) undef_count++;
      else real_items++;
    end
    in_valid_i <= 1'b0;

    // wait for the last response, then keep watching for strays
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run covered %0d requests (%0d undefined codes), %0d responses checked",
             req_count, undef_count, rsp_count);
    $display("status mix: ok %0d, full %0d, empty %0d, bad index %0d",
             status_seen[bpl_pkg::ST_OK], status_seen[bpl_pkg::ST_FULL],
             status_seen[bpl_pkg::ST_EMPTY], status_seen[bpl_pkg::ST_BAD_INDEX]);
    $display("longest receiver hold-off %0d cycles", longest_hold);
    if (shadow.mismatches == 0) begin
      $display("bounded_positional_list_top_test: PASS");
    end else begin
      $display("bounded_positional_list_top_test: FAIL");
    end
    $finish;
  end

endmodule
